// ===== rtl/mcls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcls_pkg: shared types, codes and frame helpers
// Event codes, register indexes, frame constants and the classified item type
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package mcls_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_HOST = 2'd1;
  localparam logic [1:0] CMD_RX   = 2'd2;

  localparam logic [1:0] MODE_MIT        = 2'd0;
  localparam logic [1:0] MODE_POS        = 2'd1;
  localparam logic [1:0] MODE_SPEED      = 2'd2;
  localparam logic [1:0] MODE_UNASSIGNED = 2'd3;

  localparam logic [2:0] REG_CONTROL_ID   = 3'd0;
  localparam logic [2:0] REG_FEEDBACK_ID  = 3'd1;
  localparam logic [2:0] REG_CONTROL_MODE = 3'd2;
  localparam logic [2:0] REG_TASK_RUNNING = 3'd3;
  localparam logic [2:0] REG_TIMEOUT      = 3'd4;

  localparam logic [63:0] FRAME_DISABLE = 64'hFDFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FRAME_ENABLE  = 64'hFCFF_FFFF_FFFF_FFFF;
  localparam logic [10:0] MODE_IDENT    = 11'h7FF;
  localparam logic [10:0] POS_OFFSET    = 11'h100;
  localparam logic [10:0] SPEED_OFFSET  = 11'h200;
  localparam logic [3:0]  LEN_FULL      = 4'd8;
  localparam logic [3:0]  LEN_HALF      = 4'd4;

  typedef struct packed {
    logic [10:0] control_id;
    logic [10:0] feedback_id;
    logic [1:0]  control_mode;
    logic        task_running;
    logic [15:0] online_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic        enable_request;
    logic        frame_match;
    logic [63:0] data;
  } item_t;

  function automatic logic [10:0] ctrl_ident(input cfg_t cfg);
    logic [10:0] offs;
    case (cfg.control_mode)
      MODE_POS:   offs = POS_OFFSET;
      MODE_SPEED: offs = SPEED_OFFSET;
      default:    offs = 11'd0;
    endcase
    return cfg.control_id + offs;
  endfunction

  function automatic logic [63:0] mode_frame(input cfg_t cfg);
    logic [1:0] code;
    code = (cfg.control_mode == MODE_UNASSIGNED) ? 2'd0 : cfg.control_mode + 2'd1;
    return {30'd0, code, 8'h0A, 8'h55, 4'h0, cfg.control_id[7:4],
            4'h0, cfg.control_id[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mcls_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcls_front: event classifier
// Checks received frames against the feedback and control identifiers,
// trims host payloads for speed mode and packs one item for the queue.
// ----------------------------------------------------------------------------
module mcls_front (
  input  var mcls_pkg::cfg_t  cfg,
  input  wire logic [1:0]     cmd,
  input  wire logic [31:0]    now_ms,
  input  wire logic           enable_request,
  input  wire logic [63:0]    command_payload,
  input  wire logic [10:0]    rx_ident,
  input  wire logic [63:0]    rx_payload,
  output var mcls_pkg::item_t item
);
  import mcls_pkg::*;

  logic [63:0] host_data;

  assign host_data = (cfg.control_mode == MODE_SPEED) ?
                     {32'd0, command_payload[31:0]} : command_payload;

  always_comb begin
    item.cmd            = cmd;
    item.now_ms         = now_ms;
    item.enable_request = enable_request;
    item.frame_match    = (rx_ident == cfg.feedback_id) &&
                          (rx_payload[3:0] == cfg.control_id[3:0]);
    item.data           = (cmd == CMD_HOST) ? host_data : rx_payload;
  end

endmodule

`default_nettype wire

// ===== rtl/mcls_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcls_queue: item queue
// Small register queue between the classifier and the sequencer back end.
// ----------------------------------------------------------------------------
module mcls_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  var mcls_pkg::item_t  push_item,
  output wire logic            full,
  input  wire logic            pop,
  output wire logic            not_empty,
  output var mcls_pkg::item_t  head
);
  import mcls_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcls_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcls_back: link state and frame selection
// Holds the link state, updates it per item and registers one result beat.
// ----------------------------------------------------------------------------
module mcls_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  var mcls_pkg::cfg_t   cfg,
  input  wire logic            item_valid,
  input  var mcls_pkg::item_t  item,
  output wire logic            item_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 tx_valid,
  output logic [10:0]          tx_ident,
  output logic [3:0]           tx_length,
  output logic [63:0]          tx_payload,
  output logic [63:0]          report_data,
  output logic                 motor_online
);
  import mcls_pkg::*;

  logic [31:0] last_fb;
  logic        fb_seen;
  logic        mode_ack;
  logic        motor_en;
  logic [31:0] trans_start;
  logic        trans_pending;
  logic        host_en;
  logic [63:0] host_payload;
  logic [63:0] fb_bytes;

  logic [31:0] last_fb_next;
  logic        fb_seen_next;
  logic        mode_ack_next;
  logic        motor_en_next;
  logic [31:0] trans_start_next;
  logic        trans_pending_next;
  logic        host_en_next;
  logic [63:0] host_payload_next;
  logic [63:0] fb_bytes_next;

  logic        tx_valid_next;
  logic [10:0] tx_ident_next;
  logic [3:0]  tx_length_next;
  logic [63:0] tx_payload_next;
  logic        online_next;

  logic [31:0] age;
  logic [31:0] age_next;
  logic [31:0] since_start;
  logic [63:0] mframe;

  assign item_pop    = item_valid && (!out_valid || !out_stall);
  assign age         = item.now_ms - last_fb;
  assign since_start = item.now_ms - trans_start;
  assign mframe      = mode_frame(cfg);

  always_comb begin
    last_fb_next       = last_fb;
    fb_seen_next       = fb_seen;
    mode_ack_next      = mode_ack;
    motor_en_next      = motor_en;
    trans_start_next   = trans_start;
    trans_pending_next = trans_pending;
    host_en_next       = host_en;
    host_payload_next  = host_payload;
    fb_bytes_next      = fb_bytes;
    tx_valid_next      = 1'b0;
    tx_ident_next      = 11'd0;
    tx_length_next     = 4'd0;
    tx_payload_next    = 64'd0;
    case (item.cmd)
      CMD_TICK: begin
        if (cfg.task_running) begin
          tx_valid_next  = 1'b1;
          tx_length_next = LEN_FULL;
          tx_ident_next  = ctrl_ident(cfg);
          if (!fb_seen || (age > {16'd0, cfg.online_timeout_ms})) begin
            tx_payload_next = FRAME_DISABLE;
          end else if (!mode_ack) begin
            tx_ident_next   = MODE_IDENT;
            tx_payload_next = mframe;
          end else if (!host_en) begin
            tx_payload_next = FRAME_DISABLE;
            if (motor_en && !trans_pending) begin
              trans_pending_next = 1'b1;
              trans_start_next   = item.now_ms;
            end
          end else if (!motor_en) begin
            tx_payload_next = FRAME_ENABLE;
            if (!trans_pending) begin
              trans_pending_next = 1'b1;
              trans_start_next   = item.now_ms;
            end
          end else if (cfg.control_mode == MODE_SPEED) begin
            tx_length_next  = LEN_HALF;
            tx_payload_next = {32'd0, host_payload[31:0]};
          end else begin
            tx_payload_next = host_payload;
          end
        end
      end
      CMD_HOST: begin
        host_en_next      = item.enable_request;
        host_payload_next = item.data;
      end
      CMD_RX: begin
        if (item.frame_match) begin
          last_fb_next = item.now_ms;
          fb_seen_next = 1'b1;
          // strictly later: modular difference nonzero and below half range
          if (trans_pending && (since_start != 32'd0) && !since_start[31]) begin
            if (host_en && !motor_en) begin
              trans_pending_next = 1'b0;
              motor_en_next      = 1'b1;
            end else if (!host_en && motor_en) begin
              trans_pending_next = 1'b0;
              motor_en_next      = 1'b0;
            end
          end
          if (!mode_ack && (item.data == mframe)) begin
            mode_ack_next = 1'b1;
          end else begin
            fb_bytes_next = item.data;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // online flag is judged on the state left by this item
  assign age_next    = item.now_ms - last_fb_next;
  assign online_next = fb_seen_next && mode_ack_next &&
                       (age_next < {16'd0, cfg.online_timeout_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_fb       <= 32'd0;
      fb_seen       <= 1'b0;
      mode_ack      <= 1'b0;
      motor_en      <= 1'b0;
      trans_start   <= 32'd0;
      trans_pending <= 1'b0;
      host_en       <= 1'b0;
      host_payload  <= 64'd0;
      fb_bytes      <= 64'd0;
      out_valid     <= 1'b0;
    end else begin
      if (item_pop) begin
        last_fb       <= last_fb_next;
        fb_seen       <= fb_seen_next;
        mode_ack      <= mode_ack_next;
        motor_en      <= motor_en_next;
        trans_start   <= trans_start_next;
        trans_pending <= trans_pending_next;
        host_en       <= host_en_next;
        host_payload  <= host_payload_next;
        fb_bytes      <= fb_bytes_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      tx_valid     <= tx_valid_next;
      tx_ident     <= tx_ident_next;
      tx_length    <= tx_length_next;
      tx_payload   <= tx_payload_next;
      report_data  <= fb_bytes_next;
      motor_online <= online_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/motor_can_link_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_can_link_sequencer: CAN motor link sequencer
// Takes tick, host command and received frame events and returns one beat
// per event with the frame to send, the report data and the online flag.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  in       in_valid/in_stall    cmd now_ms enable_request command_payload
//                                rx_ident rx_payload
//  out      out_valid/out_stall  tx_valid tx_ident tx_length tx_payload
//                                report_data motor_online
//  cfg      cfg_write            cfg_index cfg_data
//
//  one event per cycle sustained while out_stall is low; a taken event is
//  written into the queue, then popped into the output register
//  in_stall rises only when the QUEUE_DEPTH entry queue is full
//  out_stall holds a valid output register; the back end then stops popping
//  synchronous reset loads register defaults and clears all link state
//
module motor_can_link_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output wire logic        in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] now_ms,
  input  wire logic        enable_request,
  input  wire logic [63:0] command_payload,
  input  wire logic [10:0] rx_ident,
  input  wire logic [63:0] rx_payload,
  output wire logic        out_valid,
  input  wire logic        out_stall,
  output wire logic        tx_valid,
  output wire logic [10:0] tx_ident,
  output wire logic [3:0]  tx_length,
  output wire logic [63:0] tx_payload,
  output wire logic [63:0] report_data,
  output wire logic        motor_online,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mcls_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  q_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_id        <= 11'd1;
      cfg.feedback_id       <= 11'd0;
      cfg.control_mode      <= MODE_MIT;
      cfg.task_running      <= 1'b1;
      cfg.online_timeout_ms <= 16'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONTROL_ID:   cfg.control_id        <= cfg_data[10:0];
        REG_FEEDBACK_ID:  cfg.feedback_id       <= cfg_data[10:0];
        REG_CONTROL_MODE: cfg.control_mode      <= cfg_data[1:0];
        REG_TASK_RUNNING: cfg.task_running      <= cfg_data[0];
        REG_TIMEOUT:      cfg.online_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  mcls_front u_front (
    .cfg             (cfg),
    .cmd             (cmd),
    .now_ms          (now_ms),
    .enable_request  (enable_request),
    .command_payload (command_payload),
    .rx_ident        (rx_ident),
    .rx_payload      (rx_payload),
    .item            (front_item)
  );

  mcls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  mcls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (q_not_empty),
    .item         (head_item),
    .item_pop     (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_valid     (tx_valid),
    .tx_ident     (tx_ident),
    .tx_length    (tx_length),
    .tx_payload   (tx_payload),
    .report_data  (report_data),
    .motor_online (motor_online)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the CAN motor link sequencer
// Drives ticks, host commands and received frames with random idling on both
// sides. A behavioral copy of the link state predicts one beat per event, and
// every returned beat is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import mcls_pkg::*;

  localparam int          HALF_PERIOD = 6;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE      = 4;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic        enable_request;
    logic [63:0] command_payload;
    logic [10:0] rx_ident;
    logic [63:0] rx_payload;
  } link_event_t;

  typedef struct {
    logic        tx_valid;
    logic [10:0] tx_ident;
    logic [3:0]  tx_length;
    logic [63:0] tx_payload;
    logic [63:0] report_data;
    logic        motor_online;
  } link_reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [31:0] now_ms;
  logic        enable_request;
  logic [63:0] command_payload;
  logic [10:0] rx_ident;
  logic [63:0] rx_payload;
  logic        out_valid;
  logic        out_stall;
  logic        tx_valid;
  logic [10:0] tx_ident;
  logic [3:0]  tx_length;
  logic [63:0] tx_payload;
  logic [63:0] report_data;
  logic        motor_online;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // register copies
  logic [10:0] cfg_control_id;
  logic [10:0] cfg_feedback_id;
  logic [1:0]  cfg_mode;
  logic        cfg_running;
  logic [15:0] cfg_timeout;

  // link state copies
  logic [31:0] last_fb_ms;
  logic        fb_seen;
  logic        mode_acked;
  logic        drive_enabled;
  logic [31:0] shift_start_ms;
  logic        shift_pending;
  logic        want_enable;
  logic [63:0] host_bytes;
  logic [63:0] report_bytes;

  link_reply_t awaited_replies[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic        gaps_on = 1'b1;
  logic        hold_request = 1'b0;
  logic [31:0] now_cursor = 32'd0;

  motor_can_link_sequencer uut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [10:0] control_ident();
    case (cfg_mode)
      MODE_POS:   return cfg_control_id + POS_OFFSET;
      MODE_SPEED: return cfg_control_id + SPEED_OFFSET;
      default:    return cfg_control_id;
    endcase
  endfunction

  // bytes 0..3: id nibbles, 0x55, 0x0A; bytes 4..7: mode code little endian
  function automatic logic [63:0] mode_change_bytes();
    logic [31:0] code;
    code = (cfg_mode == MODE_UNASSIGNED) ? 32'd0 : {30'd0, cfg_mode} + 32'd1;
    return {code, 8'h0A, 8'h55, 4'h0, cfg_control_id[7:4], 4'h0, cfg_control_id[3:0]};
  endfunction

  task automatic sequence_reply(input link_event_t ev, output link_reply_t r);
    logic [31:0] since;
    logic [31:0] lag;
    r = '{default: '0};
    since = ev.now_ms - last_fb_ms;
    case (ev.cmd)
      CMD_TICK: begin
        if (cfg_running) begin
          r.tx_valid  = 1'b1;
          r.tx_length = LEN_FULL;
          r.tx_ident  = control_ident();
          if (!fb_seen || since > {16'd0, cfg_timeout}) begin
            r.tx_payload = FRAME_DISABLE;
          end else if (!mode_acked) begin
            r.tx_ident   = MODE_IDENT;
            r.tx_payload = mode_change_bytes();
          end else if (!want_enable) begin
            r.tx_payload = FRAME_DISABLE;
            if (drive_enabled && !shift_pending) begin
              shift_pending  = 1'b1;
              shift_start_ms = ev.now_ms;
            end
          end else if (!drive_enabled) begin
            r.tx_payload = FRAME_ENABLE;
            if (!shift_pending) begin
              shift_pending  = 1'b1;
              shift_start_ms = ev.now_ms;
            end
          end else if (cfg_mode == MODE_SPEED) begin
            r.tx_length  = LEN_HALF;
            r.tx_payload = {32'd0, host_bytes[31:0]};
          end else begin
            r.tx_payload = host_bytes;
          end
        end
      end
      CMD_HOST: begin
        want_enable = ev.enable_request;
        host_bytes  = (cfg_mode == MODE_SPEED) ? {32'd0, ev.command_payload[31:0]}
                                               : ev.command_payload;
      end
      CMD_RX: begin
        if (ev.rx_ident == cfg_feedback_id && ev.rx_payload[3:0] == cfg_control_id[3:0]) begin
          last_fb_ms = ev.now_ms;
          fb_seen    = 1'b1;
          lag        = ev.now_ms - shift_start_ms;
          // completion needs a strictly later frame in modular time
          if (shift_pending && lag != 32'd0 && !lag[31]) begin
            if (want_enable && !drive_enabled) begin
              shift_pending = 1'b0;
              drive_enabled = 1'b1;
            end else if (!want_enable && drive_enabled) begin
              shift_pending = 1'b0;
              drive_enabled = 1'b0;
            end
          end
          if (!mode_acked && ev.rx_payload == mode_change_bytes()) mode_acked = 1'b1;
          else report_bytes = ev.rx_payload;
        end
      end
      default: ;
    endcase
    since = ev.now_ms - last_fb_ms;
    r.report_data  = report_bytes;
    r.motor_online = fb_seen && mode_acked && (since < {16'd0, cfg_timeout});
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    link_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("tx_valid", 64'(want.tx_valid), 64'(tx_valid));
        check_field("tx_ident", 64'(want.tx_ident), 64'(tx_ident));
        check_field("tx_length", 64'(want.tx_length), 64'(tx_length));
        check_field("tx_payload", want.tx_payload, tx_payload);
        check_field("report_data", want.report_data, report_data);
        check_field("motor_online", 64'(want.motor_online), 64'(motor_online));
      end
    end
  end

  // receiver: stall rate changes in stretches, long hold-off on request
  initial begin : receiver
    int stretch_left;
    int stall_pct;
    int hold_left;
    stretch_left = 0;
    stall_pct    = 0;
    hold_left    = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(16, 96);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        stretch_left--;
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_event(input link_event_t ev);
    link_reply_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid        = 1'b1;
    cmd             = ev.cmd;
    now_ms          = ev.now_ms;
    enable_request  = ev.enable_request;
    command_payload = ev.command_payload;
    rx_ident        = ev.rx_ident;
    rx_payload      = ev.rx_payload;
    do @(posedge clk); while (in_stall);
    sequence_reply(ev, r);
    awaited_replies.push_back(r);
  endtask

  function automatic link_event_t make_event(input logic [1:0] kind, input logic [31:0] t,
                                             input logic en, input logic [63:0] bytes,
                                             input logic [10:0] id);
    link_event_t ev;
    ev.cmd             = kind;
    ev.now_ms          = t;
    ev.enable_request  = en;
    ev.command_payload = bytes;
    ev.rx_ident        = id;
    ev.rx_payload      = bytes;
    return ev;
  endfunction

  task automatic drain_replies();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (index)
      REG_CONTROL_ID:   cfg_control_id  = value[10:0];
      REG_FEEDBACK_ID:  cfg_feedback_id = value[10:0];
      REG_CONTROL_MODE: cfg_mode        = value[1:0];
      REG_TASK_RUNNING: cfg_running     = value[0];
      REG_TIMEOUT:      cfg_timeout     = value;
      default: ;
    endcase
  endtask

  task automatic random_event(output link_event_t ev);
    int kind;
    int step;
    kind = $urandom_range(0, 99);
    step = $urandom_range(0, 99);
    if (step < 4) now_cursor += $urandom;
    else if (step < 7) now_cursor -= $urandom_range(1, 40);
    else if (step < 11 && fb_seen)
      now_cursor = last_fb_ms + {16'd0, cfg_timeout} + $urandom_range(0, 2) - 1;
    else now_cursor += $urandom_range(0, 6);
    ev.cmd             = 2'($urandom_range(0, 3));
    ev.now_ms          = now_cursor;
    ev.enable_request  = 1'($urandom_range(0, 1));
    ev.command_payload = {$urandom, $urandom};
    ev.rx_ident        = 11'($urandom);
    ev.rx_payload      = {$urandom, $urandom};
    if (kind < 35) begin
      ev.cmd = CMD_TICK;
    end else if (kind < 50) begin
      ev.cmd            = CMD_HOST;
      ev.enable_request = ($urandom_range(0, 9) < 7);
    end else if (kind < 82) begin
      ev.cmd             = CMD_RX;
      ev.rx_ident        = cfg_feedback_id;
      ev.rx_payload[3:0] = cfg_control_id[3:0];
      if ((!mode_acked && $urandom_range(0, 2) == 0) || $urandom_range(0, 24) == 0)
        ev.rx_payload = mode_change_bytes();
    end else if (kind < 90) begin
      ev.cmd = CMD_RX;
    end else if (kind < 95) begin
      // right identifier, wrong id nibble
      ev.cmd             = CMD_RX;
      ev.rx_ident        = cfg_feedback_id;
      ev.rx_payload[3:0] = cfg_control_id[3:0] ^ 4'($urandom_range(1, 15));
    end else begin
      ev.cmd = CMD_UNKNOWN;
    end
  endtask

  task automatic test_reset_state();
    send_event(make_event(CMD_TICK, 32'd0, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, '1, 11'h7FF));
    send_event(make_event(CMD_HOST, 32'd0, 1'b1, '1, 11'd0));
    send_event(make_event(CMD_RX, 32'd50, 1'b0, '1, 11'h7FF));
    send_event(make_event(CMD_RX, 32'd100, 1'b0, 64'h0123_4567_89AB_CDE1, 11'd0));
  endtask

  task automatic test_enable_handshake();
    send_event(make_event(CMD_TICK, 32'd105, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_RX, 32'd106, 1'b0, mode_change_bytes(), cfg_feedback_id));
    send_event(make_event(CMD_TICK, 32'd110, 1'b0, 64'd0, 11'd0));
    // same millisecond as the enable frame: no completion yet
    send_event(make_event(CMD_RX, 32'd110, 1'b0, 64'hAAAA_5555_AAAA_5551, cfg_feedback_id));
    send_event(make_event(CMD_RX, 32'd111, 1'b0, 64'h5555_AAAA_5555_AAA1, cfg_feedback_id));
    send_event(make_event(CMD_TICK, 32'd112, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_HOST, 32'd113, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_TICK, 32'd114, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_RX, 32'd120, 1'b0, 64'hFFFF_FFFF_FFFF_FFF1, cfg_feedback_id));
  endtask

  task automatic test_link_timeout();
    send_event(make_event(CMD_TICK, 32'd1120, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_TICK, 32'd1121, 1'b0, 64'd0, 11'd0));
    send_event(make_event(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 64'd0, 11'd0));
  endtask

  task automatic test_speed_wrap();
    drain_replies();
    write_reg(REG_CONTROL_ID, 16'hFFFF);
    write_reg(REG_FEEDBACK_ID, 16'h07FF);
    write_reg(REG_CONTROL_MODE, {14'd0, MODE_SPEED});
    write_reg(REG_TIMEOUT, 16'hFFFF);
    send_event(make_event(CMD_RX, 32'hFFFF_FFF0, 1'b0, mode_change_bytes(), cfg_feedback_id));
    send_event(make_event(CMD_HOST, 32'hFFFF_FFF1, 1'b1, '1, 11'd0));
    send_event(make_event(CMD_TICK, 32'hFFFF_FFF2, 1'b0, 64'd0, 11'd0));
    // wrapped time still counts as later
    send_event(make_event(CMD_RX, 32'd3, 1'b0, 64'h8000_0000_0000_000F, cfg_feedback_id));
    send_event(make_event(CMD_TICK, 32'd4, 1'b0, 64'd0, 11'd0));
    now_cursor = 32'd4;
  endtask

  task automatic test_backpressure();
    link_event_t ev;
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    repeat (40) begin
      random_event(ev);
      send_event(ev);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_settings_sweep();
    logic [10:0] id_val;
    logic [10:0] fb_val;
    logic [1:0]  mode_val;
    logic        run_val;
    logic [15:0] limit_val;
    link_event_t ev;
    for (int phase = 0; phase < 8; phase++) begin
      id_val    = 11'($urandom);
      fb_val    = 11'($urandom);
      mode_val  = 2'($urandom_range(0, 2));
      run_val   = 1'b1;
      limit_val = 16'($urandom_range(1, 2000));
      case (phase)
        0: begin
          id_val = 11'd1; fb_val = 11'd0; mode_val = MODE_MIT; limit_val = 16'd1000;
        end
        1: begin
          id_val = 11'h7FF; fb_val = 11'h7FF; mode_val = MODE_SPEED; limit_val = 16'hFFFF;
        end
        2: begin
          id_val = 11'd0; fb_val = 11'd0; mode_val = MODE_POS; limit_val = 16'd1;
        end
        3: begin
          id_val = 11'h5A3; fb_val = 11'h201; mode_val = MODE_UNASSIGNED; limit_val = 16'd300;
        end
        4: begin
          mode_val = MODE_POS; run_val = 1'b0; limit_val = 16'd500;
        end
        5: begin
          id_val = 11'h123; fb_val = 11'h456; mode_val = MODE_MIT; limit_val = 16'd0;
        end
        7: begin
          mode_val = MODE_SPEED; limit_val = 16'd50;
        end
        default: ;
      endcase
      drain_replies();
      write_reg(REG_CONTROL_ID, {5'($urandom), id_val});
      write_reg(REG_FEEDBACK_ID, {5'($urandom), fb_val});
      write_reg(REG_CONTROL_MODE, {14'($urandom), mode_val});
      write_reg(REG_TASK_RUNNING, {15'($urandom), run_val});
      write_reg(REG_TIMEOUT, limit_val);
      if (phase == 3) write_reg(REG_UNUSED, 16'hFFFF);
      if (phase == 1) now_cursor = 32'hFFFF_FF80;
      gaps_on = (phase % 3 != 2);
      repeat (80) begin
        random_event(ev);
        send_event(ev);
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    cmd             = CMD_TICK;
    now_ms          = 32'd0;
    enable_request  = 1'b0;
    command_payload = 64'd0;
    rx_ident        = 11'd0;
    rx_payload      = 64'd0;
    cfg_write       = 1'b0;
    cfg_index       = REG_CONTROL_ID;
    cfg_data        = 16'd0;
    cfg_control_id  = 11'd1;
    cfg_feedback_id = 11'd0;
    cfg_mode        = MODE_MIT;
    cfg_running     = 1'b1;
    cfg_timeout     = 16'd1000;
    last_fb_ms      = 32'd0;
    fb_seen         = 1'b0;
    mode_acked      = 1'b0;
    drive_enabled   = 1'b0;
    shift_start_ms  = 32'd0;
    shift_pending   = 1'b0;
    want_enable     = 1'b0;
    host_bytes      = 64'd0;
    report_bytes    = 64'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_enable_handshake();
    test_link_timeout();
    test_speed_wrap();
    test_backpressure();
    test_settings_sweep();

    drain_replies();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== motor_can_link_sequencer.f =====
rtl/mcls_pkg.sv
rtl/mcls_front.sv
rtl/mcls_queue.sv
rtl/mcls_back.sv
rtl/motor_can_link_sequencer.sv
tb/testbench.sv
